/* rtl/aip_pkg.sv */
// Package for the ASCII integer parser: parse phase codes, state and
// configuration structs, and the character decode helpers.
// No dependencies.
`default_nettype none

package aip_pkg;

  // Character codes used by the parser.
  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CharNine  = 8'h39;  // '9'
  localparam logic [7:0] CharLowA  = 8'h61;  // 'a'
  localparam logic [7:0] CharLowF  = 8'h66;  // 'f'
  localparam logic [7:0] CharUpA   = 8'h41;  // 'A'
  localparam logic [7:0] CharUpF   = 8'h46;  // 'F'
  localparam logic [7:0] CharLowB  = 8'h62;  // 'b'
  localparam logic [7:0] CharUpB   = 8'h42;  // 'B'
  localparam logic [7:0] CharLowX  = 8'h78;  // 'x'
  localparam logic [7:0] CharUpX   = 8'h58;  // 'X'
  localparam logic [7:0] CharMinus = 8'h2d;  // '-'
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0d;

  // Radix values that enable prefix handling.
  localparam logic [4:0] RadixBin   = 5'd2;
  localparam logic [4:0] RadixOct   = 5'd8;
  localparam logic [4:0] RadixDec   = 5'd10;
  localparam logic [4:0] RadixHex   = 5'd16;
  localparam int unsigned ValueWidth = 64;

  // Configuration register indexes.
  localparam logic [1:0] RegRadix  = 2'd0;
  localparam logic [1:0] RegSigned = 2'd1;
  localparam logic [1:0] RegNarrow = 2'd2;

  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t                  phase;
    logic [ValueWidth-1:0]   acc;
    logic                    negative;
    logic                    digit_seen;
  } parse_state_t;

  typedef struct packed {
    logic [4:0] radix;
    logic       signed_mode;
    logic       narrow_mode;
  } cfg_t;

  // Whitespace: space, TAB, LF, VT, FF, CR.
  function automatic logic is_space(input logic [7:0] c);
    return (c == CharSpace) || (c >= CharTab && c <= CharCr);
  endfunction

  // Hex digit decode: bit 4 flags a digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CharZero && c <= CharNine) begin
      d = c - CharZero;
      return {1'b1, d[3:0]};
    end else if (c >= CharLowA && c <= CharLowF) begin
      d = c - CharLowA + 8'd10;
      return {1'b1, d[3:0]};
    end else if (c >= CharUpA && c <= CharUpF) begin
      d = c - CharUpA + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

`default_nettype wire

/* rtl/ascii_integer_parser_unit.sv */
// Top level of the streaming ASCII integer parser: handshakes, config
// registers, input and result registers. Uses aip_pkg and aip_step.
`default_nettype none

// Channel   Handshake             Payload
// input     in_valid / in_ready   char_code, string_start
// result    out_valid / out_ready number_value, converted
// config    cfg_we                cfg_index, cfg_data
//
// One character can be taken every cycle unless the held character is
// stalled by a full result slot. An accepted character waits in the input
// register, where a single multiply-add by the radix updates the
// accumulator; a stopping character's result then goes to the result register.
// Reset (synchronous, rst) restores the default registers and an empty parse.
// A stalled result holds the input register only when that character must
// emit a result too; characters that emit nothing keep flowing.

module ascii_integer_parser_unit
  import aip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            char_code,
  input  logic                  string_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ValueWidth-1:0] number_value,
  output logic                  converted,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [4:0]            cfg_data
);

  cfg_t                  cfg;
  parse_state_t          state;
  parse_state_t          state_next;
  logic                  s1_valid;
  logic [7:0]            s1_char;
  logic                  s1_start;
  logic                  step_emit;
  logic [ValueWidth-1:0] step_value;
  logic                  step_converted;
  logic                  out_free;
  logic                  fire;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{radix: RadixDec, signed_mode: 1'b1, narrow_mode: 1'b0};
    end else if (cfg_we) begin
      case (cfg_index)
        RegRadix:  cfg.radix       <= cfg_data;
        RegSigned: cfg.signed_mode <= cfg_data[0];
        RegNarrow: cfg.narrow_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  aip_step u_step (
    .cur          (state),
    .cfg          (cfg),
    .char_code    (s1_char),
    .string_start (s1_start),
    .nxt          (state_next),
    .emit         (step_emit),
    .value        (step_value),
    .converted    (step_converted)
  );

  // The held character retires unless it needs the result slot and the
  // slot is still occupied.
  assign out_free = !out_valid || out_ready;
  assign fire     = s1_valid && (!step_emit || out_free);
  assign in_ready = !s1_valid || fire;

  // Input register and parse state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      state    <= '{phase: PH_SPACE, acc: '0, negative: 1'b0, digit_seen: 1'b0};
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (fire) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char  <= char_code;
      s1_start <= string_start;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && step_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step_emit) begin
      number_value <= step_value;
      converted    <= step_converted;
    end
  end

  // Loading the result register always leaves the parse finished.
  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    fire && step_emit |=> state.phase == PH_DONE)
    else $error("parse state not finished after result");

  // Without any digit the accumulator never moved, so the value is zero.
  a_zero_when_unconverted: assert property (@(posedge clk) disable iff (rst)
    out_valid && !converted |-> number_value == '0)
    else $error("nonzero value without converted digits");

  // A held character that cannot retire stays in the input register.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !fire |=> s1_valid && $stable(s1_char) && $stable(s1_start))
    else $error("stalled character lost");

endmodule

`default_nettype wire

/* rtl/aip_step.sv */
// Next-state logic for one character of the ASCII integer parser.
// Depends on aip_pkg for the state and configuration types.
`default_nettype none

module aip_step
  import aip_pkg::*;
(
  input  parse_state_t          cur,
  input  cfg_t                  cfg,
  input  logic [7:0]            char_code,
  input  logic                  string_start,
  output parse_state_t          nxt,
  output logic                  emit,
  output logic [ValueWidth-1:0] value,
  output logic                  converted
);

  logic [ValueWidth-1:0]  product;
  logic [ValueWidth-1:0]  acc_in;
  logic [4:0]             digit;

  assign digit = hex_digit(char_code);

  // Walk the phases in order; a phase may fall through to the next one
  // within the same character, as the digit check does after a zero with no prefix letter.
  always_comb begin
    parse_state_t st;
    logic         go;
    st      = cur;
    go      = 1'b1;
    emit    = 1'b0;
    acc_in  = '0;
    product = '0;
    if (string_start) begin
      st = '{phase: PH_SPACE, acc: '0, negative: 1'b0, digit_seen: 1'b0};
    end
    if (st.phase == PH_DONE) begin
      go = 1'b0;
    end
    if (go && st.phase == PH_SPACE) begin
      if (is_space(char_code)) begin
        go = 1'b0;
      end else begin
        st.phase = PH_SIGN;
        if (cfg.signed_mode && char_code == CharMinus) begin
          st.negative = 1'b1;
          go = 1'b0;
        end
      end
    end
    if (go && st.phase == PH_SIGN) begin
      st.phase = PH_DIGITS;
      if (char_code == CharZero) begin
        if (cfg.radix == RadixOct) begin
          go = 1'b0;
        end else if (cfg.radix == RadixBin || cfg.radix == RadixHex) begin
          st.phase = PH_ZERO;
          go = 1'b0;
        end
      end
    end
    if (go && st.phase == PH_ZERO) begin
      st.phase = PH_DIGITS;
      if ((cfg.radix == RadixBin && (char_code == CharLowB || char_code == CharUpB)) ||
          (cfg.radix == RadixHex && (char_code == CharLowX || char_code == CharUpX))) begin
        go = 1'b0;
      end else begin
        // The dropped zero counts as a digit after all.
        st.acc = '0;
        st.digit_seen = 1'b1;
      end
    end
    if (go) begin
      if (digit[4] && ({1'b0, digit[3:0]} < cfg.radix)) begin
        acc_in  = st.acc;
        product = acc_in * ValueWidth'(cfg.radix) + ValueWidth'(digit[3:0]);
        st.acc  = product;
        st.digit_seen = 1'b1;
      end else begin
        emit     = 1'b1;
        st.phase = PH_DONE;
      end
    end
    nxt = st;
  end

  // Result formatting: negate if a minus was seen, then optionally narrow to 32 bits.
  always_comb begin
    logic [ValueWidth-1:0] v;
    v = cur.negative && !string_start ? (~cur.acc + 1'b1) : cur.acc;
    if (nxt.negative) begin
      v = ~nxt.acc + 1'b1;
    end else begin
      v = nxt.acc;
    end
    if (cfg.narrow_mode) begin
      v[ValueWidth-1:32] = (cfg.signed_mode && v[31]) ? '1 : '0;
    end
    value     = v;
    converted = nxt.digit_seen;
  end

endmodule

`default_nettype wire

/* verif/ascii_integer_parser_checker.sv */
// Scoreboard for the ASCII integer parser: watches the character, result and
// register write ports, predicts each parse result and compares it.
// Depends on aip_pkg for the phase codes, register indexes and char codes.
`timescale 1ns / 1ps

module ascii_integer_parser_checker
  import aip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            char_code,
  input  logic                  string_start,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [ValueWidth-1:0] number_value,
  input  logic                  converted,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [4:0]            cfg_data,
  output int                    mismatch_count,
  output int                    pending_results
);

  localparam logic [7:0] CharUpZ  = 8'h5a;
  localparam logic [7:0] CaseFold = 8'h20;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic                  conv;
  } parse_result_t;

  // Shadow of the configuration registers and of the parse state.
  cfg_t                  shadow_cfg;
  phase_t                parse_phase;
  logic [ValueWidth-1:0] digit_acc;
  logic                  minus_seen;
  logic                  any_digit;
  parse_result_t         expected_results[$];

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  function automatic void clear_parse_state();
    parse_phase = PH_SPACE;
    digit_acc   = '0;
    minus_seen  = 1'b0;
    any_digit   = 1'b0;
  endfunction

  // Advance the parse by one character; returns 1 when it ends the number.
  function automatic logic parse_char(input logic [7:0] c, input logic first,
                                      output parse_result_t res);
    logic [7:0]            folded;
    logic                  is_digit;
    logic [4:0]            digit_val;
    logic [ValueWidth-1:0] val;
    res      = '0;
    folded   = (c >= CharUpA && c <= CharUpZ) ? c + CaseFold : c;
    is_digit = 1'b1;
    if (c >= CharZero && c <= CharNine) begin
      digit_val = 5'(c - CharZero);
    end else if (folded >= CharLowA && folded <= CharLowF) begin
      digit_val = 5'(folded - CharLowA + 8'd10);
    end else begin
      is_digit  = 1'b0;
      digit_val = '0;
    end

    if (first) clear_parse_state();
    if (parse_phase == PH_DONE) return 1'b0;

    // Leading whitespace, then an optional minus in signed mode.
    if (parse_phase == PH_SPACE) begin
      if (c == CharSpace || (c >= CharTab && c <= CharCr)) return 1'b0;
      parse_phase = PH_SIGN;
      if (shadow_cfg.signed_mode && c == CharMinus) begin
        minus_seen = 1'b1;
        return 1'b0;
      end
    end

    // A leading zero is dropped in base 8 and may open a prefix in 2 or 16.
    if (parse_phase == PH_SIGN) begin
      parse_phase = PH_DIGITS;
      if (c == CharZero) begin
        if (shadow_cfg.radix == RadixOct) return 1'b0;
        if (shadow_cfg.radix == RadixBin || shadow_cfg.radix == RadixHex) begin
          parse_phase = PH_ZERO;
          return 1'b0;
        end
      end
    end

    // Prefix letter after the zero, or else the zero was a real digit.
    if (parse_phase == PH_ZERO) begin
      parse_phase = PH_DIGITS;
      if ((shadow_cfg.radix == RadixBin && folded == CharLowB) ||
          (shadow_cfg.radix == RadixHex && folded == CharLowX)) return 1'b0;
      digit_acc = '0;
      any_digit = 1'b1;
    end

    if (is_digit && digit_val < shadow_cfg.radix) begin
      digit_acc = digit_acc * ValueWidth'(shadow_cfg.radix) + ValueWidth'(digit_val);
      any_digit = 1'b1;
      return 1'b0;
    end

    // Stopping character: negate, narrow and emit.
    val = minus_seen ? -digit_acc : digit_acc;
    if (shadow_cfg.narrow_mode) begin
      val = shadow_cfg.signed_mode ? {{32{val[31]}}, val[31:0]} : {32'd0, val[31:0]};
    end
    res.value   = val;
    res.conv    = any_digit;
    parse_phase = PH_DONE;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    parse_result_t predicted;
    parse_result_t oldest;
    if (rst) begin
      shadow_cfg.radix       = RadixDec;
      shadow_cfg.signed_mode = 1'b1;
      shadow_cfg.narrow_mode = 1'b0;
      clear_parse_state();
      expected_results.delete();
    end else begin
      // Character transfer: predict under the current register values.
      if (in_valid && in_ready) begin
        if (parse_char(char_code, string_start, predicted)) begin
          expected_results.push_back(predicted);
        end
      end

      // Result transfer: compare with the oldest prediction.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got value %h converted %b",
                   $time, number_value, converted);
          mismatch_count++;
        end else begin
          oldest = expected_results.pop_front();
          if (number_value !== oldest.value) begin
            $display("%0t: number_value mismatch, expected %h, got %h",
                     $time, oldest.value, number_value);
            mismatch_count++;
          end
          if (converted !== oldest.conv) begin
            $display("%0t: converted mismatch, expected %b, got %b",
                     $time, oldest.conv, converted);
            mismatch_count++;
          end
        end
      end

      // Register writes apply from the next character on.
      if (cfg_we) begin
        case (cfg_index)
          RegRadix:  shadow_cfg.radix       = cfg_data;
          RegSigned: shadow_cfg.signed_mode = cfg_data[0];
          RegNarrow: shadow_cfg.narrow_mode = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending_results = expected_results.size();
  end

endmodule

/* verif/ascii_integer_parser_unit_test.sv */
// Top of the ASCII integer parser test: clock, reset, character stimulus,
// register sweeps and result back-pressure, plus the final verdict.
// Depends on aip_pkg, ascii_integer_parser_unit and ascii_integer_parser_checker.
`timescale 1ns / 1ps

module ascii_integer_parser_unit_test;
  import aip_pkg::*;

  localparam int NumPhases     = 12;
  localparam int CharsPerPhase = 62;
  localparam int SettleCycles  = 4;
  localparam int HoldCycles    = 80;
  localparam int TimeLimitNs   = 1000000;

  localparam logic [7:0] CharNul = 8'h00;
  localparam logic [7:0] CharMax = 8'hff;

  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [7:0]            char_code    = 8'd0;
  logic                  string_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [ValueWidth-1:0] number_value;
  logic                  converted;
  logic                  cfg_we       = 1'b0;
  logic [1:0]            cfg_index    = RegRadix;
  logic [4:0]            cfg_data     = 5'd0;
  int                    mismatch_count;
  int                    pending_results;

  // Stimulus knobs, some shared with the receiver process.
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_requests = 0;
  int         holds_done    = 0;
  int         hold_left     = 0;
  int         chars_sent    = 0;
  logic       start_pending = 1'b0;
  logic [4:0] cur_radix     = RadixDec;

  // Register settings swept by the random part, extremes included.
  logic [4:0] phase_radix  [NumPhases] = '{RadixHex, RadixBin, RadixOct, 5'd31, 5'd0,
                                           RadixHex, RadixOct, 5'd1, RadixBin, RadixDec,
                                           5'd3, RadixDec};
  logic       phase_signed [NumPhases] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1,
                                           1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
  logic       phase_narrow [NumPhases] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1,
                                           1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  ascii_integer_parser_unit uut (.*);

  ascii_integer_parser_checker result_checker (.*);

  // Result side: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_done) begin
      out_ready  <= 1'b0;
      holds_done <= holds_done + 1;
      hold_left  <= HoldCycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one character and hold it until its transfer; returns at a falling edge.
  task automatic send_char(input logic [7:0] c, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    char_code    <= c;
    string_start <= first;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic put_char(input logic [7:0] c);
    send_char(c, start_pending);
    start_pending = 1'b0;
  endtask

  task automatic send_text(input string s);
    int i;
    start_pending = 1'b1;
    for (i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  // Stop offering and let every expected result arrive, then let the pipe empty.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_config(input logic [4:0] r, input logic s, input logic n);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_index <= RegRadix;
    cfg_data  <= r;
    @(negedge clk);
    cfg_index <= RegSigned;
    cfg_data  <= {4'($urandom_range(15)), s};
    @(negedge clk);
    cfg_index <= RegNarrow;
    cfg_data  <= {4'($urandom_range(15)), n};
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_radix = r;
  endtask

  // One string: mostly a well-formed number with random content, sometimes
  // noise, a cut-off string or trailing characters after the stop.
  task automatic send_random_string();
    int         n;
    int         k;
    int         top_digit;
    int         v;
    logic [7:0] c;
    start_pending = 1'b1;
    if ($urandom_range(7) == 0) begin
      n = $urandom_range(6, 1);
      for (k = 0; k < n; k++) put_char(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(3, 1);
        for (k = 0; k < n; k++) begin
          put_char($urandom_range(1) ? CharSpace : 8'($urandom_range(CharCr, CharTab)));
        end
      end
      if ($urandom_range(2) == 0) begin
        put_char(CharMinus);
        if ($urandom_range(15) == 0) put_char(CharSpace);
      end

      // Optional zero, followed by a prefix letter, a wrong one or nothing.
      if ($urandom_range(2) == 0) begin
        put_char(CharZero);
        k = $urandom_range(4);
        if (cur_radix == RadixBin || cur_radix == RadixHex) begin
          case (k)
            0: put_char(cur_radix == RadixBin ? CharLowB : CharLowX);
            1: put_char(cur_radix == RadixBin ? CharUpB : CharUpX);
            2: put_char(cur_radix == RadixBin ? CharLowX : CharUpB);
            default: ;
          endcase
        end
      end

      top_digit = (cur_radix == 0 || cur_radix > RadixHex) ? 15 : int'(cur_radix) - 1;
      n = ($urandom_range(7) == 0) ? $urandom_range(40, 12) : $urandom_range(8);
      for (k = 0; k < n; k++) begin
        v = $urandom_range(top_digit);
        if (v < 10) c = CharZero + 8'(v);
        else c = ($urandom_range(1) ? CharUpA : CharLowA) + 8'(v - 10);
        put_char(c);
      end

      // Stopping character; none at all leaves the parse to be abandoned.
      case ($urandom_range(9))
        0: ;
        1: put_char(CharNul);
        2: put_char(CharSpace);
        3: put_char(CharMax);
        4: put_char(CharMinus);
        default: put_char(8'($urandom_range(255)));
      endcase
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(3, 1);
        for (k = 0; k < n; k++) put_char(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    int p;
    int phase_end;
    bit paused;
    paused = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed strings under the reset settings: sign, stop after minus,
    // abandoned string, immediate stop.
    send_text(" -99");
    put_char(CharNul);
    send_text("- 7");
    send_text("12");
    send_text("3");
    put_char(CharMax);
    send_text("x");

    // Directed hex prefixes: full prefix, prefix with no digits, bare zero.
    set_config(RadixHex, 1'b0, 1'b0);
    send_text("0Xff\n");
    send_text("0x");
    put_char(CharNul);
    send_text("01g");

    // Random part over the register sweep.
    for (p = 0; p < NumPhases; p++) begin
      set_config(phase_radix[p], phase_signed[p], phase_narrow[p]);
      if (p < 4) begin
        send_idle_pct = 29;
        recv_idle_pct <= 62;
      end else if (p < 8) begin
        send_idle_pct = 62;
        recv_idle_pct <= 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      if (p == 1 || p == 9) hold_requests <= hold_requests + 1;
      phase_end = chars_sent + CharsPerPhase;
      while (chars_sent < phase_end) begin
        if (p == 5 && !paused && chars_sent >= phase_end - CharsPerPhase / 2) begin
          wait_for_results();
          paused = 1'b1;
        end
        send_random_string();
      end
    end

    wait_for_results();
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("ascii_integer_parser_unit_test OK");
    end else begin
      $display("ascii_integer_parser_unit_test NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TimeLimitNs);
    $display("ascii_integer_parser_unit_test NOT OK");
    $finish;
  end

endmodule
